@@ rtl/c2r_pkg.sv @@
`default_nettype none
package c2r_pkg;

	// 1.0 in the 15-bit fraction format
	localparam logic [14:0] FracOne = 15'd32760;
	localparam logic [27:0] DivStep = 28'd4095;
	localparam logic [27:0] DivStep2 = 28'd8190;
	localparam logic [7:0] ByteMax = 8'd255;

	typedef enum logic [1:0] {
		ReqRgb  = 2'd0,
		ReqHsb  = 2'd1,
		ReqCmyk = 2'd2,
		ReqGray = 2'd3
	} c2r_space_t;

	// products and side data leaving the front end
	typedef struct packed {
		logic              valid;
		logic              use_mux;
		logic [2:0]        sector;
		logic [14:0]       val;
		logic              direct;
		logic [2:0][14:0]  pass;
		logic [29:0]       mprod;
		logic [29:0]       sfprod;
		logic [2:0][29:0]  cprod;
	} c2r_prod_t;

	// channel fractions ready for byte scaling
	typedef struct packed {
		logic              valid;
		logic [2:0][15:0]  frac;
	} c2r_frac_t;

	function automatic logic [14:0] sat_frac(input logic [14:0] x);
		logic [14:0] r;
		r = (x > FracOne) ? FracOne : x;
		return r;
	endfunction

	// first guess of floor(x / 32760), low by at most two
	function automatic logic [15:0] quot_est(input logic [29:0] x);
		logic [26:0] y;
		logic [27:0] sum;
		y = x[29:3];
		sum = {1'b0, y} + {13'd0, y[26:12]};
		return sum[27:12];
	endfunction

	// correct the guess from its remainder against 4095
	function automatic logic [15:0] quot_fix(input logic [29:0] x, input logic [15:0] q0);
		logic [26:0] y;
		logic [27:0] back;
		logic [27:0] rem;
		logic [15:0] q;
		y = x[29:3];
		back = {q0, 12'd0} - {12'd0, q0};
		rem = {1'b0, y} - back;
		q = q0 + {15'd0, rem >= DivStep} + {15'd0, rem >= DivStep2};
		return q;
	endfunction

	// black deduction quotient: ((p >> 3) + (p >> 15) + 1) >> 12
	function automatic logic [15:0] black_frac(input logic [29:0] p);
		logic [27:0] s;
		s = {1'b0, p[29:3]} + {13'd0, p[29:15]} + 28'd1;
		return s[27:12];
	endfunction

endpackage
`default_nettype wire

@@ rtl/c2r_prep.sv @@
`default_nettype none
module c2r_prep (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [1:0]        req_type,
	input  wire logic [14:0]       comp_a,
	input  wire logic [14:0]       comp_b,
	input  wire logic [14:0]       comp_c,
	input  wire logic [14:0]       comp_d,
	output c2r_pkg::c2r_prod_t     prod
);

	logic [14:0] a, b, c, d;
	logic [17:0] h6;
	logic [2:0] sector;
	logic [17:0] sec_off;
	logic [14:0] kk;
	logic k_zero, k_one;
	logic [14:0] notk;
	logic [2:0][14:0] comp;
	logic [2:0][14:0] inv;
	logic [2:0][14:0] pass;
	logic is_hsb, is_rgb, is_gray;
	logic direct;

	logic valid_s1, use_mux_s1, direct_s1;
	logic [2:0] sector_s1;
	logic [14:0] f_s1, sat_s1, val_s1, notk_s1;
	logic [2:0][14:0] inv_s1, pass_s1;

	logic valid_s2, use_mux_s2, direct_s2;
	logic [2:0] sector_s2;
	logic [14:0] val_s2;
	logic [2:0][14:0] pass_s2;
	logic [29:0] mprod_s2, sfprod_s2;
	logic [2:0][29:0] cprod_s2;

	always_comb begin
		a = c2r_pkg::sat_frac(comp_a);
		b = c2r_pkg::sat_frac(comp_b);
		c = c2r_pkg::sat_frac(comp_c);
		d = c2r_pkg::sat_frac(comp_d);
		comp[0] = a;
		comp[1] = b;
		comp[2] = c;
		is_hsb = (req_type == c2r_pkg::ReqHsb);
		is_rgb = (req_type == c2r_pkg::ReqRgb);
		is_gray = (req_type == c2r_pkg::ReqGray);

		// sector = floor(6h / 1.0), remainder kept as F
		h6 = {1'b0, a, 2'b00} + {2'b00, a, 1'b0};
		sector = 3'd0;
		sec_off = 18'd0;
		for (int k = 1; k <= 6; k++) begin
			if (h6 >= 18'(k) * {3'd0, c2r_pkg::FracOne}) begin
				sector = 3'(k);
				sec_off = 18'(k) * {3'd0, c2r_pkg::FracOne};
			end
		end

		// gray is cmyk with no ink and black = 1.0 - gray
		kk = is_gray ? (c2r_pkg::FracOne - a) : d;
		k_zero = (kk == 15'd0);
		k_one = (kk == c2r_pkg::FracOne);
		notk = c2r_pkg::FracOne - kk;
		for (int i = 0; i < 3; i++) begin
			inv[i] = is_gray ? c2r_pkg::FracOne : (c2r_pkg::FracOne - comp[i]);
			if (is_hsb)
				pass[i] = c;
			else if (is_rgb)
				pass[i] = comp[i];
			else if (k_zero)
				pass[i] = inv[i];
			else
				pass[i] = 15'd0;
		end
		direct = is_hsb | is_rgb | k_zero | k_one;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		use_mux_s1 <= is_hsb & (b != 15'd0);
		direct_s1 <= direct;
		sector_s1 <= sector;
		f_s1 <= 15'(h6 - sec_off);
		sat_s1 <= b;
		val_s1 <= c;
		notk_s1 <= notk;
		inv_s1 <= inv;
		pass_s1 <= pass;

		use_mux_s2 <= use_mux_s1;
		direct_s2 <= direct_s1;
		sector_s2 <= sector_s1;
		val_s2 <= val_s1;
		pass_s2 <= pass_s1;
		mprod_s2 <= {15'd0, val_s1} * {15'd0, c2r_pkg::FracOne - sat_s1};
		sfprod_s2 <= {15'd0, sat_s1} * {15'd0, f_s1};
		for (int i = 0; i < 3; i++) begin
			cprod_s2[i] <= {15'd0, inv_s1[i]} * {15'd0, notk_s1};
		end
	end

	always_comb begin
		prod.valid = valid_s2;
		prod.use_mux = use_mux_s2;
		prod.sector = sector_s2;
		prod.val = val_s2;
		prod.direct = direct_s2;
		prod.pass = pass_s2;
		prod.mprod = mprod_s2;
		prod.sfprod = sfprod_s2;
		prod.cprod = cprod_s2;
	end

endmodule
`default_nettype wire

@@ rtl/c2r_resolve.sv @@
`default_nettype none
module c2r_resolve (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire c2r_pkg::c2r_prod_t prod,
	output c2r_pkg::c2r_frac_t fracs
);

	logic valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	logic use_mux_s3, use_mux_s4, use_mux_s5, use_mux_s6;
	logic [2:0] sector_s3, sector_s4, sector_s5, sector_s6;
	logic [14:0] val_s3, val_s4, val_s5, val_s6;
	logic [2:0][15:0] frac_s3, frac_s4, frac_s5, frac_s6, frac_s7;
	logic [29:0] mx_s3, tx_s3;
	logic [15:0] mq_s3, tq_s3;
	logic [15:0] m_s4, t_s4, m_s5, m_s6;
	logic [29:0] nx_s5, nx_s6;
	logic [15:0] nq_s6;

	logic [2:0][15:0] cfrac;
	logic [15:0] tdiff;
	logic [30:0] nfull;
	logic [15:0] n, kv, v16;
	logic [16:0] ksum;
	logic [2:0][15:0] hsb;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cfrac[i] = prod.direct ? {1'b0, prod.pass[i]} : c2r_pkg::black_frac(prod.cprod[i]);
		end
		tdiff = {1'b0, c2r_pkg::FracOne} - t_s4;
		nfull = {16'd0, val_s4} * {15'd0, tdiff};

		n = c2r_pkg::quot_fix(nx_s6, nq_s6);
		v16 = {1'b0, val_s6};
		ksum = {1'b0, m_s6} + {1'b0, v16} - {1'b0, n};
		kv = ksum[15:0];
		case (sector_s6)
			3'd1: begin
				hsb[0] = n;    hsb[1] = v16;  hsb[2] = m_s6;
			end
			3'd2: begin
				hsb[0] = m_s6; hsb[1] = v16;  hsb[2] = kv;
			end
			3'd3: begin
				hsb[0] = m_s6; hsb[1] = n;    hsb[2] = v16;
			end
			3'd4: begin
				hsb[0] = kv;   hsb[1] = m_s6; hsb[2] = v16;
			end
			3'd5: begin
				hsb[0] = v16;  hsb[1] = m_s6; hsb[2] = n;
			end
			default: begin
				// sector zero, and a hue of exactly 1.0
				hsb[0] = v16;  hsb[1] = kv;   hsb[2] = m_s6;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s3 <= prod.valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		use_mux_s3 <= prod.use_mux;
		sector_s3 <= prod.sector;
		val_s3 <= prod.val;
		frac_s3 <= cfrac;
		mx_s3 <= prod.mprod;
		tx_s3 <= prod.sfprod;
		mq_s3 <= c2r_pkg::quot_est(prod.mprod);
		tq_s3 <= c2r_pkg::quot_est(prod.sfprod);

		use_mux_s4 <= use_mux_s3;
		sector_s4 <= sector_s3;
		val_s4 <= val_s3;
		frac_s4 <= frac_s3;
		m_s4 <= c2r_pkg::quot_fix(mx_s3, mq_s3);
		t_s4 <= c2r_pkg::quot_fix(tx_s3, tq_s3);

		use_mux_s5 <= use_mux_s4;
		sector_s5 <= sector_s4;
		val_s5 <= val_s4;
		frac_s5 <= frac_s4;
		m_s5 <= m_s4;
		nx_s5 <= nfull[29:0];

		use_mux_s6 <= use_mux_s5;
		sector_s6 <= sector_s5;
		val_s6 <= val_s5;
		frac_s6 <= frac_s5;
		m_s6 <= m_s5;
		nx_s6 <= nx_s5;
		nq_s6 <= c2r_pkg::quot_est(nx_s5);

		frac_s7 <= use_mux_s6 ? hsb : frac_s6;
	end

	always_comb begin
		fracs.valid = valid_s7;
		fracs.frac = frac_s7;
	end

endmodule
`default_nettype wire

@@ rtl/c2r_scale.sv @@
`default_nettype none
module c2r_scale (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire c2r_pkg::c2r_frac_t fracs,
	output logic               done,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);

	logic valid_s8, valid_s9;
	logic [2:0][29:0] x_s8;
	logic [2:0][15:0] q0_s8;
	logic [2:0][7:0] byte_s9;

	logic [2:0][29:0] x;
	logic [2:0][15:0] q;
	logic [2:0][7:0] bytes;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// frac * 255
			x[i] = {6'd0, fracs.frac[i], 8'd0} - {14'd0, fracs.frac[i]};
			q[i] = c2r_pkg::quot_fix(x_s8[i], q0_s8[i]);
			bytes[i] = (q[i] > {8'd0, c2r_pkg::ByteMax}) ? c2r_pkg::ByteMax : q[i][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s8 <= fracs.valid;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		x_s8 <= x;
		for (int i = 0; i < 3; i++) begin
			q0_s8[i] <= c2r_pkg::quot_est(x[i]);
		end
		byte_s9 <= bytes;
	end

	assign done = valid_s9;
	assign red = byte_s9[0];
	assign green = byte_s9[1];
	assign blue = byte_s9[2];

endmodule
`default_nettype wire

@@ rtl/color_to_rgb_converter.sv @@
// color to rgb converter
// a request is taken at a rising edge where start is high and busy is low;
// req_type picks the color space (rgb, hsb, cmyk, gray) and comp_a..comp_d
// carry the components as 15-bit fractions where 32760 stands for 1.0.
// values above 32760 are clipped to 1.0 first.
// each request gives one result: red, green, blue bytes shown for a single
// cycle with done high; done is driven by valid_s9, the last register of
// the valid chain that the request passes through.
// busy is always low: a new request may enter every cycle and up to nine
// are in flight at once, so throughput is one request per clock.
// the latency comes from the chain of products and reciprocal divides by
// 32760: hsb needs M and S*F/1.0 first, then the N product and its divide,
// then every channel is scaled by 255/32760 in two more stages.
// reset clears only the valid bits of the pipeline; results in flight are
// dropped and nothing is shown until new requests arrive.
// the receiver cannot stall, so done is never held or repeated.
`default_nettype none
module color_to_rgb_converter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [14:0] comp_a,
	input  wire logic [14:0] comp_b,
	input  wire logic [14:0] comp_c,
	input  wire logic [14:0] comp_d,
	output logic             done,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue
);

	c2r_pkg::c2r_prod_t prod;
	c2r_pkg::c2r_frac_t fracs;

	assign busy = 1'b0;

	c2r_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.req_type (req_type),
		.comp_a   (comp_a),
		.comp_b   (comp_b),
		.comp_c   (comp_c),
		.comp_d   (comp_d),
		.prod     (prod)
	);

	c2r_resolve u_resolve (
		.clk    (clk),
		.arst_n (arst_n),
		.prod   (prod),
		.fracs  (fracs)
	);

	c2r_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.fracs  (fracs),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;

	localparam int unsigned UnitFrac = 32760;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		c2r_pkg::c2r_space_t space;
		logic [14:0] a;
		logic [14:0] b;
		logic [14:0] c;
		logic [14:0] d;
		bit          fixed;
		rgb_t        want;
	} color_req_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	c2r_pkg::c2r_space_t req_type = c2r_pkg::ReqRgb;
	logic [14:0] comp_a = '0;
	logic [14:0] comp_b = '0;
	logic [14:0] comp_c = '0;
	logic [14:0] comp_d = '0;
	logic        done;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;

	// travels with the request so the monitor knows a typed-in answer
	bit          row_fixed = 1'b0;
	rgb_t        row_want = '0;

	color_req_t  stim_table[$];
	color_req_t  pending_rgb[$];
	int unsigned err_count = 0;

	color_to_rgb_converter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.comp_a   (comp_a),
		.comp_b   (comp_b),
		.comp_c   (comp_c),
		.comp_d   (comp_d),
		.done     (done),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic int unsigned clamp_frac(input logic [14:0] x);
		return (x > UnitFrac) ? UnitFrac : int'(x);
	endfunction

	function automatic logic [7:0] frac_byte(input int unsigned f);
		longint unsigned t;
		t = (64'(f) * 64'd255) / UnitFrac;
		return (t > 255) ? 8'd255 : t[7:0];
	endfunction

	// (1 - v) * (1 - k) with the shift-add divide by 32760
	function automatic int unsigned scale_by_notk(input int unsigned v, input int unsigned notk);
		longint unsigned p;
		p = 64'(UnitFrac - v) * 64'(notk);
		return 32'(((p >> 3) + (p >> 15) + 64'd1) >> 12);
	endfunction

	function automatic void cmyk_fracs(input int unsigned c, input int unsigned m,
			input int unsigned y, input int unsigned k, output int unsigned fr,
			output int unsigned fg, output int unsigned fb);
		if (k == 0) begin
			fr = UnitFrac - c;
			fg = UnitFrac - m;
			fb = UnitFrac - y;
		end else if (k == UnitFrac) begin
			fr = 0;
			fg = 0;
			fb = 0;
		end else begin
			fr = scale_by_notk(c, UnitFrac - k);
			fg = scale_by_notk(m, UnitFrac - k);
			fb = scale_by_notk(y, UnitFrac - k);
		end
	endfunction

	function automatic rgb_t convert_color(input c2r_pkg::c2r_space_t space,
			input logic [14:0] a_in, input logic [14:0] b_in, input logic [14:0] c_in,
			input logic [14:0] d_in);
		int unsigned a, b, c, d;
		int unsigned fr, fg, fb;
		int unsigned h6, sector, f, mm, nn, kk, sf;
		rgb_t res;
		a = clamp_frac(a_in);
		b = clamp_frac(b_in);
		c = clamp_frac(c_in);
		d = clamp_frac(d_in);
		case (space)
			c2r_pkg::ReqRgb: begin
				fr = a;
				fg = b;
				fb = c;
			end
			c2r_pkg::ReqHsb: begin
				if (b == 0) begin
					fr = c;
					fg = c;
					fb = c;
				end else begin
					h6 = a * 6;
					sector = h6 / UnitFrac;
					f = h6 % UnitFrac;
					mm = 32'((64'(c) * 64'(UnitFrac - b)) / UnitFrac);
					sf = 32'((64'(b) * 64'(f)) / UnitFrac);
					nn = 32'((64'(c) * 64'(UnitFrac - sf)) / UnitFrac);
					kk = mm + c - nn;
					// hue of exactly one lands in sector six and acts as sector zero
					case (sector)
						1: begin fr = nn; fg = c;  fb = mm; end
						2: begin fr = mm; fg = c;  fb = kk; end
						3: begin fr = mm; fg = nn; fb = c;  end
						4: begin fr = kk; fg = mm; fb = c;  end
						5: begin fr = c;  fg = mm; fb = nn; end
						default: begin fr = c; fg = kk; fb = mm; end
					endcase
				end
			end
			c2r_pkg::ReqCmyk: cmyk_fracs(a, b, c, d, fr, fg, fb);
			default: cmyk_fracs(0, 0, 0, UnitFrac - a, fr, fg, fb);
		endcase
		res.red = frac_byte(fr);
		res.green = frac_byte(fg);
		res.blue = frac_byte(fb);
		return res;
	endfunction

	function automatic void add_row(input c2r_pkg::c2r_space_t space, input int a, input int b,
			input int c, input int d, input bit fixed, input int r, input int g,
			input int bl);
		color_req_t row;
		row.space = space;
		row.a = a[14:0];
		row.b = b[14:0];
		row.c = c[14:0];
		row.d = d[14:0];
		row.fixed = fixed;
		row.want = '{r[7:0], g[7:0], bl[7:0]};
		stim_table.push_back(row);
	endfunction

	function automatic logic [14:0] rand_comp();
		case ($urandom_range(0, 9))
			0: return 15'd0;
			1: return 15'(UnitFrac);
			2: return 15'($urandom_range(32761, 32767));
			default: return 15'($urandom_range(0, 32767));
		endcase
	endfunction

	function automatic color_req_t random_row();
		color_req_t row;
		row.space = c2r_pkg::c2r_space_t'($urandom_range(0, 3));
		row.a = rand_comp();
		row.b = rand_comp();
		row.c = rand_comp();
		row.d = rand_comp();
		if (row.space == c2r_pkg::ReqHsb && $urandom_range(0, 7) == 0) begin
			row.b = 15'd0;
		end
		if (row.space == c2r_pkg::ReqCmyk) begin
			case ($urandom_range(0, 7))
				0: row.d = 15'd0;
				1: row.d = 15'(UnitFrac);
				default: ;
			endcase
		end
		row.fixed = 1'b0;
		row.want = '0;
		return row;
	endfunction

	task automatic send_color(input color_req_t row, input bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= row.space;
		comp_a <= row.a;
		comp_b <= row.b;
		comp_c <= row.c;
		comp_d <= row.d;
		row_fixed <= row.fixed;
		row_want <= row.want;
		do @(posedge clk); while (busy);
	endtask

	// hold off new requests until every outstanding result is back
	task automatic drain_results();
		int unsigned spin;
		spin = 0;
		start <= 1'b0;
		@(posedge clk);
		while (pending_rgb.size() != 0 && spin < 200) begin
			@(posedge clk);
			spin++;
		end
		if (pending_rgb.size() != 0) begin
			report_mismatch($sformatf("%0d results never came", pending_rgb.size()));
			pending_rgb.delete();
		end
	endtask

	always @(posedge clk) begin
		color_req_t got;
		if (arst_n && done) begin
			if (pending_rgb.size() == 0) begin
				report_mismatch($sformatf("result %h %h %h with no request waiting",
					red, green, blue));
			end else begin
				got = pending_rgb.pop_front();
				if (red !== got.want.red)
					report_mismatch($sformatf("%s %h %h %h %h: red %h, want %h",
						got.space.name(), got.a, got.b, got.c, got.d, red, got.want.red));
				if (green !== got.want.green)
					report_mismatch($sformatf("%s %h %h %h %h: green %h, want %h",
						got.space.name(), got.a, got.b, got.c, got.d, green, got.want.green));
				if (blue !== got.want.blue)
					report_mismatch($sformatf("%s %h %h %h %h: blue %h, want %h",
						got.space.name(), got.a, got.b, got.c, got.d, blue, got.want.blue));
			end
		end
		if (arst_n && start && !busy) begin
			got.space = req_type;
			got.a = comp_a;
			got.b = comp_b;
			got.c = comp_c;
			got.d = comp_d;
			got.fixed = row_fixed;
			got.want = row_fixed ? row_want : convert_color(req_type, comp_a, comp_b,
				comp_c, comp_d);
			pending_rgb.push_back(got);
		end
	end

	initial begin
		color_req_t row;
		int i;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(c2r_pkg::ReqRgb, 0, 0, 0, 0, 1, 0, 0, 0);
		add_row(c2r_pkg::ReqRgb, 32760, 32760, 32760, 0, 1, 255, 255, 255);
		add_row(c2r_pkg::ReqRgb, 32767, 32761, 32764, 32767, 1, 255, 255, 255);
		add_row(c2r_pkg::ReqRgb, 129, 16380, 32759, 21845, 0, 0, 0, 0);
		add_row(c2r_pkg::ReqCmyk, 0, 0, 0, 0, 1, 255, 255, 255);
		add_row(c2r_pkg::ReqCmyk, 32760, 32760, 32767, 0, 1, 0, 0, 0);
		add_row(c2r_pkg::ReqCmyk, 1000, 20000, 5, 32760, 1, 0, 0, 0);
		add_row(c2r_pkg::ReqCmyk, 1000, 20000, 5, 32767, 1, 0, 0, 0);
		add_row(c2r_pkg::ReqCmyk, 0, 16380, 32760, 16380, 0, 0, 0, 0);
		add_row(c2r_pkg::ReqCmyk, 0, 12345, 32767, 1, 0, 0, 0, 0);
		add_row(c2r_pkg::ReqCmyk, 0, 300, 32000, 32759, 0, 0, 0, 0);
		add_row(c2r_pkg::ReqGray, 32760, 5, 5, 5, 1, 255, 255, 255);
		add_row(c2r_pkg::ReqGray, 0, 32767, 0, 32767, 1, 0, 0, 0);
		add_row(c2r_pkg::ReqGray, 32767, 0, 0, 0, 1, 255, 255, 255);
		add_row(c2r_pkg::ReqGray, 16380, 0, 0, 0, 0, 0, 0, 0);
		add_row(c2r_pkg::ReqHsb, 9000, 0, 32760, 0, 1, 255, 255, 255);
		add_row(c2r_pkg::ReqHsb, 20000, 0, 0, 0, 1, 0, 0, 0);
		add_row(c2r_pkg::ReqHsb, 0, 32760, 32760, 0, 1, 255, 0, 0);
		add_row(c2r_pkg::ReqHsb, 32760, 32760, 32760, 0, 1, 255, 0, 0);
		add_row(c2r_pkg::ReqHsb, 32767, 32767, 32767, 32767, 1, 255, 0, 0);
		add_row(c2r_pkg::ReqHsb, 1000, 20000, 30000, 0, 0, 0, 0, 0);
		for (i = 1; i < 6; i++) begin
			add_row(c2r_pkg::ReqHsb, 5460 * i + 1000, 20000, 30000, 32767, 0, 0, 0, 0);
		end

		foreach (stim_table[j]) send_color(stim_table[j], 1'b1);
		drain_results();

		for (i = 0; i < 1200; i++) begin
			if (i == 600) drain_results();
			row = random_row();
			// no idling over the last stretch so back-to-back requests get covered
			send_color(row, i < 1000);
		end
		drain_results();
		repeat (12) @(posedge clk);

		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/c2r_pkg.sv
rtl/c2r_prep.sv
rtl/c2r_resolve.sv
rtl/c2r_scale.sv
rtl/color_to_rgb_converter.sv
dv/tb.sv
